@@ rtl/assert_macros.svh @@
// assertion helpers used by terrain_height_curve_mapper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while rst is high
`define THM_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("thm check failed");

// next-cycle implication, also checked across reset
`define THM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("thm check failed");

`endif

@@ rtl/thm_pkg.sv @@
`timescale 1ns / 1ps
package thm_pkg;
  localparam int MAX_POINTS_DEF = 16;
  localparam int HEIGHT_DEF = 256;
  localparam int NUM_CURVES = 3;
  localparam int ELEV_MAX = 511;

  // operation codes
  localparam logic OP_EVALUATE = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // curve codes
  localparam logic [1:0] CURVE_CONT = 2'd0;
  localparam logic [1:0] CURVE_EROSION = 2'd1;
  localparam logic [1:0] CURVE_PEAKS = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_CONT_POINTS = 2'd0;
  localparam logic [1:0] REG_EROSION_POINTS = 2'd1;
  localparam logic [1:0] REG_PEAKS_POINTS = 2'd2;

  // quotient bits of the interpolation divide (|height| <= 256)
  localparam int QBITS = 9;

  // pipeline stage numbers
  localparam int ST_MEM = 2;
  localparam int ST_DIV = 5;
  localparam int ST_HGT = ST_DIV + QBITS;
  localparam int ST_MUL = ST_HGT + 1;
  localparam int ST_SUM = ST_MUL + 1;
  localparam int ST_OUT = ST_SUM + 1;
  localparam int NSTAGE = ST_OUT + 1;

  typedef struct packed {
    logic              acc;
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld;
  } pipe_ctl_t;
endpackage

@@ rtl/thm_req_if.sv @@
`timescale 1ns / 1ps
interface thm_req_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [1:0]        curve_select;
  logic [3:0]        point_index;
  logic signed [15:0] point_x;
  logic signed [8:0] point_height;
  logic signed [15:0] continental_noise;
  logic signed [15:0] erosion_noise;
  logic signed [15:0] peaks_noise;
  logic signed [15:0] plane_noise;

  modport source(output valid, operation, curve_select, point_index, point_x, point_height,
                 continental_noise, erosion_noise, peaks_noise, plane_noise, input ready);
  modport sink(input valid, operation, curve_select, point_index, point_x, point_height,
               continental_noise, erosion_noise, peaks_noise, plane_noise, output ready);
endinterface

@@ rtl/thm_rsp_if.sv @@
`timescale 1ns / 1ps
interface thm_rsp_if;
  logic              valid;
  logic              ready;
  logic [8:0]        elevation;
  logic              clamped;
  logic signed [8:0] continental_height;
  logic signed [8:0] erosion_height;
  logic signed [8:0] peaks_height;

  modport source(output valid, elevation, clamped, continental_height, erosion_height,
                 peaks_height, input ready);
  modport sink(input valid, elevation, clamped, continental_height, erosion_height,
               peaks_height, output ready);
endinterface

@@ rtl/thm_cfg_if.sv @@
`timescale 1ns / 1ps
interface thm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/thm_curve.sv @@
`timescale 1ns / 1ps
module thm_curve #(
  parameter int MAX_POINTS = thm_pkg::MAX_POINTS_DEF,
  parameter logic [1:0] CID = thm_pkg::CURVE_CONT
) (
  input  logic               clk,
  input  thm_pkg::pipe_ctl_t ctl,
  input  logic               operation,
  input  logic [1:0]         curve_select,
  input  logic [3:0]         point_index,
  input  logic signed [15:0] point_x,
  input  logic signed [8:0]  point_height,
  input  logic signed [15:0] noise,
  input  logic [4:0]         count,
  output logic signed [8:0]  height
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int RW = 28;
  localparam int QB = thm_pkg::QBITS;

  // compare copy of the breakpoints and the point memory
  logic signed [15:0] xr [MAX_POINTS];
  logic [24:0] mem [MAX_POINTS];

  logic [NW-1:0] n;
  logic wr_acc;
  logic [AW-1:0] widx;
  logic [MAX_POINTS-1:0] lt_c;

  // stage 0
  logic wr0;
  logic [AW-1:0] idx0;
  logic signed [15:0] px0;
  logic signed [8:0] ph0;
  logic signed [15:0] v0;
  logic [MAX_POINTS-1:0] lt0;

  // stage 1
  logic [NW-1:0] pos;
  logic flat_c;
  logic [AW-1:0] ra_c, rb_c;
  logic wr1;
  logic [AW-1:0] idx1;
  logic signed [15:0] px1;
  logic signed [8:0] ph1;
  logic signed [15:0] v1;
  logic [AW-1:0] ra1, rb1;
  logic flat1;

  // stage 2
  logic [24:0] rda, rdb;
  logic signed [15:0] v2;
  logic flat2;
  logic signed [15:0] xa, xb;
  logic signed [8:0] ha, hb;
  logic signed [16:0] den_c, dv_c;
  logic signed [9:0] dh_c;

  // stage 3
  logic signed [25:0] pa3;
  logic signed [26:0] pb3;
  logic [15:0] den3;
  logic flat3;
  logic signed [8:0] ha3;

  // stage 4
  logic signed [27:0] num_c;
  logic [RW-1:0] r4;
  logic neg4, flat4;
  logic [15:0] den4;
  logic signed [8:0] ha4;

  // divider stages
  logic [RW-1:0] dr [QB];
  logic [QB-1:0] dq [QB];
  logic [15:0] dd [QB];
  logic dn [QB];
  logic df [QB];
  logic signed [8:0] dhh [QB];

  // effective point count
  always_comb begin
    if (count == 5'd0) begin
      n = NW'(1);
    end else if (32'(count) > MAX_POINTS) begin
      n = NW'(MAX_POINTS);
    end else begin
      n = NW'(count);
    end
  end

  assign wr_acc = ctl.acc && (operation == thm_pkg::OP_LOAD) && (curve_select == CID)
                  && (32'(point_index) < MAX_POINTS);
  assign widx = AW'(point_index);

  always_ff @(posedge clk) begin
    if (wr_acc) begin
      xr[widx] <= point_x;
    end
  end

  // one comparator per point
  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      lt_c[k] = (32'(n) > k) && (noise < xr[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      wr0 <= wr_acc;
      idx0 <= widx;
      px0 <= point_x;
      ph0 <= point_height;
      v0 <= noise;
      lt0 <= lt_c;
    end
  end

  // first point above the sample
  always_comb begin
    pos = n;
    for (int k = MAX_POINTS - 1; k >= 0; k--) begin
      if (lt0[k]) begin
        pos = NW'(k);
      end
    end
  end

  assign flat_c = (pos == '0) || (pos == n);

  always_comb begin
    if (pos == '0) begin
      ra_c = '0;
    end else begin
      ra_c = AW'(pos - NW'(1));
    end
    rb_c = flat_c ? ra_c : AW'(pos);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      wr1 <= wr0;
      idx1 <= idx0;
      px1 <= px0;
      ph1 <= ph0;
      v1 <= v0;
      ra1 <= ra_c;
      rb1 <= rb_c;
      flat1 <= flat_c;
    end
  end

  // point memory: loads write here in order with evaluate reads
  always_ff @(posedge clk) begin
    if (ctl.en[thm_pkg::ST_MEM] && ctl.vld[thm_pkg::ST_MEM-1] && wr1) begin
      mem[idx1] <= {px1, ph1};
    end
    if (ctl.en[thm_pkg::ST_MEM]) begin
      rda <= mem[ra1];
      rdb <= mem[rb1];
      v2 <= v1;
      flat2 <= flat1;
    end
  end

  assign xa = rda[24:9];
  assign ha = rda[8:0];
  assign xb = rdb[24:9];
  assign hb = rdb[8:0];
  assign den_c = 17'(xb) - 17'(xa);
  assign dv_c = 17'(v2) - 17'(xa);
  assign dh_c = 10'(hb) - 10'(ha);

  // partial products of the interpolation numerator
  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      pa3 <= 26'(ha) * 26'(den_c);
      pb3 <= 27'(dh_c) * 27'(dv_c);
      den3 <= den_c[15:0];
      flat3 <= flat2;
      ha3 <= ha;
    end
  end

  assign num_c = 28'(pa3) + 28'(pb3);

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      neg4 <= num_c[27];
      r4 <= num_c[27] ? RW'(-num_c) : RW'(num_c);
      den4 <= den3;
      flat4 <= flat3;
      ha4 <= ha3;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [RW-1:0] r_in;
    logic [QB-1:0] q_in;
    logic [15:0] d_in;
    logic n_in, f_in;
    logic signed [8:0] h_in;
    logic [RW-1:0] dsh;

    if (j == 0) begin : g_first
      assign r_in = r4;
      assign q_in = '0;
      assign d_in = den4;
      assign n_in = neg4;
      assign f_in = flat4;
      assign h_in = ha4;
    end else begin : g_rest
      assign r_in = dr[j-1];
      assign q_in = dq[j-1];
      assign d_in = dd[j-1];
      assign n_in = dn[j-1];
      assign f_in = df[j-1];
      assign h_in = dhh[j-1];
    end

    assign dsh = RW'(d_in) << (QB - 1 - j);

    always_ff @(posedge clk) begin
      if (ctl.en[thm_pkg::ST_DIV+j]) begin
        if (r_in >= dsh) begin
          dr[j] <= r_in - dsh;
          dq[j] <= q_in | (QB'(1) << (QB - 1 - j));
        end else begin
          dr[j] <= r_in;
          dq[j] <= q_in;
        end
        dd[j] <= d_in;
        dn[j] <= n_in;
        df[j] <= f_in;
        dhh[j] <= h_in;
      end
    end
  end

  // flat ends take the stored height, otherwise signed quotient
  always_ff @(posedge clk) begin
    if (ctl.en[thm_pkg::ST_HGT]) begin
      if (df[QB-1]) begin
        height <= dhh[QB-1];
      end else if (dn[QB-1]) begin
        height <= 9'(-$signed({1'b0, dq[QB-1]}));
      end else begin
        height <= 9'($signed({1'b0, dq[QB-1]}));
      end
    end
  end
endmodule

@@ rtl/terrain_height_curve_mapper.sv @@
`timescale 1ns / 1ps
// terrain height curve mapper
// req channel: operation selects a point load or a column evaluate. a load
// writes one breakpoint (curve_select, point_index, point_x, point_height)
// and returns nothing. an evaluate carries four q1.15 noise samples and
// returns one beat on rsp with the clamped elevation, the clamp flag and
// the three raw curve heights.
// cfg channel: always ready; index 0..2 sets the point count of the
// continental, erosion and peaks curve. write it only while idle.
// an accepted evaluate beat reaches its rsp beat through the 9-stage
// quotient divide of the interpolation plus lookup, product and summing
// stages. throughput: one beat per cycle while rsp is ready.
// every stage has its own valid bit, so bubbles close up and req stays
// ready while a result waits on rsp until all 18 stages are full. a stalled
// rsp holds its beat and backs up the pipe one stage at a time; nothing is
// dropped.
// reset empties the pipe and sets all point counts to 1. the curve
// tables are not cleared; load every used point before evaluating.
module terrain_height_curve_mapper #(
  parameter int MAX_POINTS = thm_pkg::MAX_POINTS_DEF,
  parameter int HEIGHT = thm_pkg::HEIGHT_DEF
) (
  input logic        clk,
  input logic        rst,
  thm_req_if.sink    req,
  thm_rsp_if.source  rsp,
  thm_cfg_if.sink    cfg
);
  `include "assert_macros.svh"

  localparam int NS = thm_pkg::NSTAGE;
  localparam int NC = thm_pkg::NUM_CURVES;
  localparam int LIMIT = (HEIGHT < thm_pkg::ELEV_MAX) ? HEIGHT : thm_pkg::ELEV_MAX;
  localparam int EVN = thm_pkg::ST_MEM + 1;

  logic [NS-1:0] vld;
  logic [NS:0] en;
  logic ev [EVN];
  thm_pkg::pipe_ctl_t ctl;
  logic [4:0] cnt [NC];
  logic signed [15:0] nz [NC];
  logic signed [8:0] hgt [NC];
  logic signed [17:0] wsum;
  logic [15:0] w_in;
  logic [15:0] wp [thm_pkg::ST_MUL];

  logic signed [8:0] h15 [NC];
  logic signed [25:0] pe15, pp15;
  logic signed [26:0] s16_c;
  logic signed [8:0] h16 [NC];
  logic signed [10:0] e16;
  logic signed [25:0] pp16;
  logic signed [27:0] t17_c;
  logic signed [11:0] raw_c;

  // stage enables: a stage moves when empty or when the next one moves
  assign en[NS] = rsp.ready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign req.ready = en[0];
  assign cfg.ready = 1'b1;
  assign ctl.acc = req.valid && en[0];
  assign ctl.en = en[NS-1:0];
  assign ctl.vld = vld;

  // valid bits; loads leave the pipe after the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= req.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          if (k == EVN) begin
            vld[k] <= vld[k-1] && ev[EVN-1];
          end else begin
            vld[k] <= vld[k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ev[0] <= (req.operation == thm_pkg::OP_EVALUATE);
    end
    for (int k = 1; k < EVN; k++) begin
      if (en[k]) begin
        ev[k] <= ev[k-1];
      end
    end
  end

  // point count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NC; c++) begin
        cnt[c] <= 5'd1;
      end
    end else if (cfg.valid) begin
      unique case (cfg.index)
        thm_pkg::REG_CONT_POINTS: cnt[thm_pkg::CURVE_CONT] <= cfg.data;
        thm_pkg::REG_EROSION_POINTS: cnt[thm_pkg::CURVE_EROSION] <= cfg.data;
        thm_pkg::REG_PEAKS_POINTS: cnt[thm_pkg::CURVE_PEAKS] <= cfg.data;
        default: ;
      endcase
    end
  end

  // plane weight 0.5 - 0.5*noise in q0.16, full scale saturates
  assign wsum = 18'sd32768 - 18'(req.plane_noise);
  assign w_in = wsum[16] ? 16'hFFFF : wsum[15:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      wp[0] <= w_in;
    end
    for (int k = 1; k < thm_pkg::ST_MUL; k++) begin
      if (en[k]) begin
        wp[k] <= wp[k-1];
      end
    end
  end

  assign nz[thm_pkg::CURVE_CONT] = req.continental_noise;
  assign nz[thm_pkg::CURVE_EROSION] = req.erosion_noise;
  assign nz[thm_pkg::CURVE_PEAKS] = req.peaks_noise;

  for (genvar c = 0; c < NC; c++) begin : g_curve
    thm_curve #(
      .MAX_POINTS(MAX_POINTS),
      .CID(2'(c))
    ) u_curve (
      .clk(clk),
      .ctl(ctl),
      .operation(req.operation),
      .curve_select(req.curve_select),
      .point_index(req.point_index),
      .point_x(req.point_x),
      .point_height(req.point_height),
      .noise(nz[c]),
      .count(cnt[c]),
      .height(hgt[c])
    );
  end

  // weight products
  always_ff @(posedge clk) begin
    if (en[thm_pkg::ST_MUL]) begin
      h15 <= hgt;
      pe15 <= 26'(hgt[thm_pkg::CURVE_EROSION]) * 26'($signed({1'b0, wp[thm_pkg::ST_MUL-1]}));
      pp15 <= 26'(hgt[thm_pkg::CURVE_PEAKS]) * 26'($signed({1'b0, wp[thm_pkg::ST_MUL-1]}));
    end
  end

  // continental plus weighted erosion, truncated toward zero
  assign s16_c = (27'(h15[thm_pkg::CURVE_CONT]) <<< 16) + 27'(pe15);

  always_ff @(posedge clk) begin
    if (en[thm_pkg::ST_SUM]) begin
      h16 <= h15;
      pp16 <= pp15;
      e16 <= 11'(s16_c >>> 16) + 11'(s16_c[26] && (s16_c[15:0] != 16'd0));
    end
  end

  // plus weighted peaks, truncated toward zero
  assign t17_c = (28'(e16) <<< 16) + 28'(pp16);
  assign raw_c = 12'(t17_c >>> 16) + 12'(t17_c[27] && (t17_c[15:0] != 16'd0));

  // clamp and output register
  always_ff @(posedge clk) begin
    if (en[thm_pkg::ST_OUT]) begin
      rsp.continental_height <= h16[thm_pkg::CURVE_CONT];
      rsp.erosion_height <= h16[thm_pkg::CURVE_EROSION];
      rsp.peaks_height <= h16[thm_pkg::CURVE_PEAKS];
      if (raw_c < 12'sd0) begin
        rsp.elevation <= 9'd0;
        rsp.clamped <= 1'b1;
      end else if (int'(raw_c) > LIMIT) begin
        rsp.elevation <= 9'(LIMIT);
        rsp.clamped <= 1'b1;
      end else begin
        rsp.elevation <= raw_c[8:0];
        rsp.clamped <= 1'b0;
      end
    end
  end

  assign rsp.valid = vld[NS-1];

  // checks
  `THM_ASSERT(a_empty_pipe_ready, (vld == '0), req.ready)
  `THM_ASSERT(a_elevation_range, rsp.valid, (int'(rsp.elevation) <= LIMIT))
  `THM_ASSERT_NEXT(a_reset_flushes, rst, (!rsp.valid && (vld == '0)))
endmodule
